FILE: rtl/ffe_pkg.sv
// framebuffer fill engine package: op codes, widths, controller states and
// the command and status structs between controller and datapath
// no dependencies
package ffe_pkg;

	// default screen size
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	// internal signed coordinate width, square width, gradient divider widths
	localparam int CW  = 14;
	localparam int SQW = 24;
	localparam int DW  = 19;
	localparam int RW  = 12;
	localparam int DCW = 5;

	// command op codes
	localparam logic [2:0] OP_PIXEL = 3'd0;
	localparam logic [2:0] OP_FILL  = 3'd1;
	localparam logic [2:0] OP_GRAD  = 3'd2;
	localparam logic [2:0] OP_ROUND = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SETUP,
		ST_BASE,
		ST_ROW,
		ST_CINIT,
		ST_CSEARCH,
		ST_GMUL,
		ST_DIV,
		ST_SPAN,
		ST_PIX,
		ST_NEXT,
		ST_RADDR,
		ST_RDATA
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic base;
		logic row_plain;
		logic corner_init;
		logic search_step;
		logic corner_done;
		logic grad_mul;
		logic div_step;
		logic span;
		logic pix_step;
		logic next_row;
		logic clr_step;
		logic mem_we;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       row_done;
		logic       corner_row;
		logic       grad_row;
		logic       search_done;
		logic       div_last;
		logic       span_empty;
		logic       pix_last;
		logic       clr_last;
		logic       out_busy;
	} sts_t;

endpackage

FILE: rtl/ffe_ram.sv
// generic single-port ram with registered read
// no dependencies
module ffe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, old data returned on a write cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/ffe_ctrl.sv
// framebuffer fill engine controller: sequences clear pass, row walk,
// corner search, gradient divide and read-back
// depends on ffe_pkg
module ffe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffe_pkg::sts_t  sts,
	output ffe_pkg::cmd_t  cmd,
	output ffe_pkg::state_t state
);

	ffe_pkg::state_t state_q, state_d;

	assign state = state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffe_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ffe_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.mem_we   = 1'b1;
				if (sts.clr_last) state_d = ffe_pkg::ST_IDLE;
			end
			ffe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ffe_pkg::ST_DISPATCH;
				end
			end
			ffe_pkg::ST_DISPATCH: begin
				case (sts.op)
					ffe_pkg::OP_PIXEL, ffe_pkg::OP_FILL,
					ffe_pkg::OP_GRAD, ffe_pkg::OP_ROUND: state_d = ffe_pkg::ST_SETUP;
					ffe_pkg::OP_READ: state_d = ffe_pkg::ST_BASE;
					default: state_d = ffe_pkg::ST_IDLE;
				endcase
			end
			ffe_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ffe_pkg::ST_BASE;
			end
			ffe_pkg::ST_BASE: begin
				cmd.base = 1'b1;
				state_d  = (sts.op == ffe_pkg::OP_READ) ? ffe_pkg::ST_RADDR : ffe_pkg::ST_ROW;
			end
			ffe_pkg::ST_ROW: begin
				if (sts.row_done) begin
					state_d = ffe_pkg::ST_IDLE;
				end else if (sts.corner_row) begin
					state_d = ffe_pkg::ST_CINIT;
				end else begin
					cmd.row_plain = 1'b1;
					state_d = sts.grad_row ? ffe_pkg::ST_GMUL : ffe_pkg::ST_SPAN;
				end
			end
			ffe_pkg::ST_CINIT: begin
				cmd.corner_init = 1'b1;
				state_d = ffe_pkg::ST_CSEARCH;
			end
			ffe_pkg::ST_CSEARCH: begin
				if (sts.search_done) begin
					cmd.corner_done = 1'b1;
					state_d = ffe_pkg::ST_SPAN;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ffe_pkg::ST_GMUL: begin
				cmd.grad_mul = 1'b1;
				state_d = ffe_pkg::ST_DIV;
			end
			ffe_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ffe_pkg::ST_SPAN;
			end
			ffe_pkg::ST_SPAN: begin
				cmd.span = 1'b1;
				state_d  = ffe_pkg::ST_PIX;
			end
			ffe_pkg::ST_PIX: begin
				if (sts.span_empty) begin
					state_d = ffe_pkg::ST_NEXT;
				end else begin
					cmd.mem_we   = 1'b1;
					cmd.pix_step = 1'b1;
					if (sts.pix_last) state_d = ffe_pkg::ST_NEXT;
				end
			end
			ffe_pkg::ST_NEXT: begin
				cmd.next_row = 1'b1;
				state_d = ffe_pkg::ST_ROW;
			end
			ffe_pkg::ST_RADDR: begin
				state_d = ffe_pkg::ST_RDATA;
			end
			ffe_pkg::ST_RDATA: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ffe_pkg::ST_IDLE;
				end
			end
			default: state_d = ffe_pkg::ST_CLEAR;
		endcase
	end

endmodule

FILE: rtl/ffe_dp.sv
// framebuffer fill engine datapath: command registers, row and span walk,
// corner square search, gradient divider, address and result register
// depends on ffe_pkg
module ffe_dp #(
	parameter int SCREEN_WIDTH  = ffe_pkg::SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = ffe_pkg::SCREEN_HEIGHT,
	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffe_pkg::cmd_t       cmd,
	output ffe_pkg::sts_t       sts,
	input  logic [2:0]          op,
	input  logic signed [11:0]  pos_x,
	input  logic signed [11:0]  pos_y,
	input  logic signed [11:0]  rect_width,
	input  logic signed [11:0]  rect_height,
	input  logic signed [11:0]  radius,
	input  logic [7:0]          color_a,
	input  logic [7:0]          color_b,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          pixel_value,
	output logic [AW-1:0]       mem_addr,
	output logic [7:0]          mem_wdata,
	input  logic [7:0]          mem_rdata
);

	localparam int CW  = ffe_pkg::CW;
	localparam int SQW = ffe_pkg::SQW;
	localparam int DW  = ffe_pkg::DW;
	localparam int RW  = ffe_pkg::RW;
	localparam int XW  = $clog2(SCREEN_WIDTH);
	localparam int YW  = $clog2(SCREEN_HEIGHT);
	localparam logic signed [CW-1:0] SW = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SH = CW'(SCREEN_HEIGHT);

	logic [2:0]           op_q;
	logic signed [CW-1:0] x_q, y_q, w_q, h_q, r_q;
	logic [7:0]           ca_q, cb_q, color_q;
	logic                 corner_q, rd_ok_q, neg_q;
	logic signed [CW-1:0] j_q, j1_q, i_q, n_q, xcur_q, xend_q;
	logic signed [SQW-1:0] rr_q, r1sq_q, limit_q, sq_q;
	logic [AW-1:0]        rowbase_q, clr_q;
	logic [DW-1:0]        quo_q;
	logic [RW-1:0]        rem_q;
	logic [ffe_pkg::DCW-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic [7:0]           pixel_q;

	logic signed [CW-1:0] in_x, in_y, in_w, in_h, in_r, yrow, jj, lo, hi;
	logic [7:0]           mag;
	logic [RW-1:0]        shifted, den;

	assign in_x = CW'(pos_x);
	assign in_y = CW'(pos_y);
	assign in_w = (op == ffe_pkg::OP_PIXEL) ? CW'(1) : CW'(rect_width);
	assign in_h = (op == ffe_pkg::OP_PIXEL) ? CW'(1) : CW'(rect_height);
	assign in_r = CW'(radius);

	assign yrow = y_q + j_q;
	assign jj   = (j_q < r_q) ? (r_q - CW'(1) - j_q) : (j_q - (h_q - r_q));
	assign lo   = x_q + r_q - n_q;
	assign hi   = x_q + w_q - r_q + n_q;
	assign mag  = (cb_q >= ca_q) ? (cb_q - ca_q) : (ca_q - cb_q);
	assign shifted = {rem_q[RW-2:0], quo_q[DW-1]};
	assign den  = RW'(h_q[RW-2:0]) - RW'(1);

	// status to controller
	always_comb begin
		sts.op          = op_q;
		sts.row_done    = (j_q >= j1_q) || (w_q <= 0);
		sts.corner_row  = corner_q && ((j_q < r_q) || (j_q >= h_q - r_q));
		sts.grad_row    = (op_q == ffe_pkg::OP_GRAD) && (h_q > CW'(1));
		sts.search_done = (i_q < 0) || (sq_q <= limit_q);
		sts.div_last    = (div_cnt_q == ffe_pkg::DCW'(DW - 1));
		sts.span_empty  = (xcur_q >= xend_q);
		sts.pix_last    = (xcur_q + CW'(1) >= xend_q);
		sts.clr_last    = (clr_q == AW'(DEPTH - 1));
		sts.out_busy    = out_valid_q && !out_ready;
	end

	// memory port: clear counter during the clear pass, else row base plus column
	assign mem_addr  = cmd.clr_step ? clr_q : (rowbase_q + AW'(xcur_q[XW-1:0]));
	assign mem_wdata = cmd.clr_step ? 8'd0 : color_q;

	// command and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			x_q      <= in_x;
			y_q      <= in_y;
			w_q      <= in_w;
			h_q      <= in_h;
			ca_q     <= color_a;
			cb_q     <= color_b;
			j_q      <= '0;
			xcur_q   <= in_x;
			rd_ok_q  <= (in_x >= 0) && (in_x < SW) && (in_y >= 0) && (in_y < SH);
			if ((op == ffe_pkg::OP_ROUND) && (in_r > 0) && (in_w >= (in_r <<< 1))
					&& (in_h >= (in_r <<< 1))) begin
				corner_q <= 1'b1;
				r_q      <= in_r;
			end else begin
				corner_q <= 1'b0;
				r_q      <= '0;
			end
		end
		// row range clipped to the screen and corner squares
		if (cmd.setup) begin
			j_q    <= (y_q < 0) ? -y_q : '0;
			j1_q   <= (h_q < SH - y_q) ? h_q : (SH - y_q);
			rr_q   <= SQW'(r_q) * SQW'(r_q);
			r1sq_q <= SQW'(r_q - CW'(1)) * SQW'(r_q - CW'(1));
		end
		if (cmd.base) begin
			rowbase_q <= AW'(yrow[YW-1:0]) * AW'(SCREEN_WIDTH);
		end
		if (cmd.row_plain) begin
			n_q <= r_q;
		end
		// corner width search by stepping the square down
		if (cmd.corner_init) begin
			limit_q <= rr_q - SQW'(jj) * SQW'(jj);
			i_q     <= r_q - CW'(1);
			sq_q    <= r1sq_q;
		end
		if (cmd.search_step) begin
			i_q  <= i_q - CW'(1);
			sq_q <= sq_q - (SQW'(i_q) <<< 1) + SQW'(1);
		end
		if (cmd.corner_done) begin
			n_q <= i_q + CW'(1);
		end
		// gradient: magnitude product then restoring divide by height minus one
		if (cmd.grad_mul) begin
			neg_q     <= (cb_q < ca_q);
			quo_q     <= DW'(mag) * DW'(j_q[RW-2:0]);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + ffe_pkg::DCW'(1);
			if (shifted >= den) begin
				rem_q <= shifted - den;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
		// horizontal span clipped to the screen
		if (cmd.span) begin
			xcur_q <= (lo < 0) ? '0 : lo;
			xend_q <= (hi > SW) ? SW : hi;
			if (sts.grad_row) begin
				color_q <= neg_q ? (ca_q - quo_q[7:0]) : (ca_q + quo_q[7:0]);
			end else begin
				color_q <= ca_q;
			end
		end
		if (cmd.pix_step) begin
			xcur_q <= xcur_q + CW'(1);
		end
		if (cmd.next_row) begin
			j_q       <= j_q + CW'(1);
			rowbase_q <= rowbase_q + AW'(SCREEN_WIDTH);
		end
		if (cmd.out_load) begin
			pixel_q <= rd_ok_q ? mem_rdata : 8'd0;
		end
	end

	// clear counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;

endmodule

FILE: rtl/framebuffer_fill_engine_core.sv
// framebuffer fill engine top level: controller, datapath and frame ram
// depends on ffe_pkg, ffe_ctrl, ffe_dp, ffe_ram
//
// Drawing commands enter on the input channel (in_valid / in_ready) with
// op, position, size, radius and two colors; one is taken whenever the
// engine is idle. Only the read command returns a transfer on the output
// channel (out_valid / out_ready) carrying pixel_value, 0 off screen.
// After reset the frame store is swept to zero, one pixel a cycle, over all
// SCREEN_WIDTH*SCREEN_HEIGHT locations before in_ready first rises.
// A read passes the dispatch, base, address and data states. A fill passes
// dispatch, setup and base, then per on-screen row a row check, span set-up,
// pixel walk and row step; gradient rows add a product step and the divider,
// rounded corner rows a search set-up and the corner square search. The pixel
// walk does one write per cycle through the single ram port.
// A result waiting on a stalled receiver stays in the output register; a
// following read waits until it is taken, drawing commands go ahead.
module framebuffer_fill_engine_core #(
	parameter int SCREEN_WIDTH  = ffe_pkg::SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = ffe_pkg::SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic signed [11:0] rect_width,
	input  logic signed [11:0] rect_height,
	input  logic signed [11:0] radius,
	input  logic [7:0]         color_a,
	input  logic [7:0]         color_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pixel_value
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	ffe_pkg::cmd_t   cmd;
	ffe_pkg::sts_t   sts;
	ffe_pkg::state_t state;
	logic [AW-1:0]   mem_addr;
	logic [7:0]      mem_wdata, mem_rdata;

	// sequencer
	ffe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	// datapath
	ffe_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.radius      (radius),
		.color_a     (color_a),
		.color_b     (color_b),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.pixel_value (pixel_value),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	// frame store
	ffe_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (cmd.mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// writes stay inside the frame store
	a_we_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> (mem_addr < AW'(DEPTH)))
		else $error("frame store write out of range");

	// no command is taken during the clear pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ffe_pkg::ST_CLEAR) |-> !in_ready)
		else $error("input taken during clear pass");

	// a finished read lands in the output register on the next cycle
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("read result not presented");

endmodule
